>>> rtl/cpr_pkg.sv
// shared types and constants of the collision pair push resolver
package cpr_pkg;

  localparam int PosW  = 20;
  localparam int SizeW = 16;
  localparam int MagW  = 17;
  localparam int RootW = 25;
  localparam int RadW  = 27;
  localparam int SqW   = 50;
  localparam int QuoW  = 18;

  typedef enum logic [1:0] {
    MODE_CC   = 2'd0,
    MODE_CR   = 2'd1,
    MODE_RR   = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef struct packed {
    logic            hit;
    logic            circ;
    logic            neg_x;
    logic            neg_y;
    logic [PosW-1:0] dir_x;
    logic [PosW-1:0] dir_y;
  } res_t;

  typedef struct packed {
    logic            scl4;
    logic [MagW-1:0] adx;
    logic [MagW-1:0] ady;
    logic [MagW-1:0] rad;
  } geo_t;

  typedef struct packed {
    logic [SqW-1:0]   v;
    logic [RadW-1:0]  rem;
    logic [RootW-1:0] root;
    geo_t             geo;
    res_t             res;
  } sq_t;

  typedef struct packed {
    logic [QuoW-1:0] nlo_x;
    logic [QuoW-1:0] nlo_y;
    logic [RadW-1:0] rem_x;
    logic [RadW-1:0] rem_y;
    logic [RadW-1:0] d;
    logic [QuoW-1:0] q_x;
    logic [QuoW-1:0] q_y;
    res_t            res;
  } dv_t;

endpackage

>>> rtl/cpr_front.sv
// geometry front end: offsets, clamping, squares, overlap test and direct pushes
module cpr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [1:0]         mode_i,
  input  logic signed [19:0] a_x_i,
  input  logic signed [19:0] a_y_i,
  input  logic [15:0]        a_width_i,
  input  logic [15:0]        a_height_i,
  input  logic signed [19:0] b_x_i,
  input  logic signed [19:0] b_y_i,
  input  logic [15:0]        b_width_i,
  input  logic [15:0]        b_height_i,
  output logic               vld_o,
  output cpr_pkg::sq_t       data_o
);
  import cpr_pkg::*;

  // stage 1
  logic               v1_q;
  mode_e              mode1_q;
  logic signed [20:0] dx1_d, dx1_q, dy1_d, dy1_q;
  logic [15:0]        aw1_q, bw1_q, bh1_q;
  logic [16:0]        sw1_d, sw1_q, sh1_d, sh1_q;

  assign dx1_d = 21'(a_x_i) - 21'(b_x_i);
  assign dy1_d = 21'(a_y_i) - 21'(b_y_i);
  assign sw1_d = 17'(a_width_i) + 17'(b_width_i);
  assign sh1_d = 17'(a_height_i) + 17'(b_height_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode_e'(mode_i);
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;
      aw1_q   <= a_width_i;
      bw1_q   <= b_width_i;
      bh1_q   <= b_height_i;
      sw1_q   <= sw1_d;
      sh1_q   <= sh1_d;
    end
  end

  // stage 2
  logic signed [22:0] ox, oy, bwe, bhe, clx, cly;
  logic [21:0]        aox, aoy;
  logic [22:0]        m1x, m1y, m2x, m2y;
  logic               v2_q;
  mode_e              mode2_q;
  logic signed [22:0] cdx2_d, cdx2_q, cdy2_d, cdy2_q;
  logic [16:0]        rad2_d, rad2_q;
  logic [17:0]        magx2_d, magx2_q, magy2_d, magy2_q;
  logic               ov2_d, ov2_q, selx2_d, selx2_q, negx2_q, negy2_q;

  always_comb begin
    ox  = $signed({dx1_q[20], dx1_q, 1'b0});
    oy  = $signed({dy1_q[20], dy1_q, 1'b0});
    bwe = $signed({7'b0, bw1_q});
    bhe = $signed({7'b0, bh1_q});
    aox = ox[22] ? 22'(-ox) : 22'(ox);
    aoy = oy[22] ? 22'(-oy) : 22'(oy);
    if (ox > bwe) begin
      clx = ox - bwe;
    end else if (ox < -bwe) begin
      clx = ox + bwe;
    end else begin
      clx = '0;
    end
    if (oy > bhe) begin
      cly = oy - bhe;
    end else if (oy < -bhe) begin
      cly = oy + bhe;
    end else begin
      cly = '0;
    end
    m1x = 23'(bw1_q) + 23'({aw1_q, 1'b0}) - 23'(aox);
    m1y = 23'(bh1_q) + 23'({aw1_q, 1'b0}) - 23'(aoy);
    m2x = 23'(sw1_q) - 23'(aox);
    m2y = 23'(sh1_q) - 23'(aoy);
    if (mode1_q == MODE_CR) begin
      cdx2_d  = clx;
      cdy2_d  = cly;
      rad2_d  = {aw1_q, 1'b0};
      magx2_d = m1x[17:0];
      magy2_d = m1y[17:0];
    end else begin
      cdx2_d  = 23'(dx1_q);
      cdy2_d  = 23'(dy1_q);
      rad2_d  = sw1_q;
      magx2_d = m2x[17:0];
      magy2_d = m2y[17:0];
    end
    ov2_d   = (aox < 22'(sw1_q)) && (aoy < 22'(sh1_q));
    selx2_d = (aox > aoy) || ((aox == '0) && (aoy == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode2_q  <= mode1_q;
      cdx2_q   <= cdx2_d;
      cdy2_q   <= cdy2_d;
      rad2_q   <= rad2_d;
      magx2_q  <= magx2_d;
      magy2_q  <= magy2_d;
      ov2_q    <= ov2_d;
      selx2_q  <= selx2_d;
      negx2_q  <= dx1_q[20];
      negy2_q  <= dy1_q[20];
    end
  end

  // stage 3
  logic signed [45:0] px, py;
  logic [16:0]        rndx, rndy;
  logic [19:0]        vx, vy;
  logic               v3_q;
  mode_e              mode3_q;
  logic [45:0]        sx3_q, sy3_q;
  logic [33:0]        rr3_d, rr3_q;
  logic [16:0]        adx3_d, adx3_q, ady3_d, ady3_q, rad3_q;
  logic               cnx3_q, cny3_q, ov3_q;
  logic [19:0]        dirx3_d, dirx3_q, diry3_d, diry3_q;

  always_comb begin
    px     = cdx2_q * cdx2_q;
    py     = cdy2_q * cdy2_q;
    rr3_d  = 34'(rad2_q) * 34'(rad2_q);
    adx3_d = cdx2_q[22] ? 17'(-cdx2_q) : 17'(cdx2_q);
    ady3_d = cdy2_q[22] ? 17'(-cdy2_q) : 17'(cdy2_q);
    rndx   = 17'((20'(magx2_q) + 20'd2) >> 2);
    rndy   = 17'((20'(magy2_q) + 20'd2) >> 2);
    vx     = negx2_q ? 20'd0 - 20'(rndx) : 20'(rndx);
    vy     = negy2_q ? 20'd0 - 20'(rndy) : 20'(rndy);
    if (mode2_q == MODE_CR) begin
      dirx3_d = vx;
      diry3_d = vy;
    end else if (selx2_q) begin
      dirx3_d = vx;
      diry3_d = '0;
    end else begin
      dirx3_d = '0;
      diry3_d = vy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode3_q <= mode2_q;
      sx3_q   <= px;
      sy3_q   <= py;
      rr3_q   <= rr3_d;
      adx3_q  <= adx3_d;
      ady3_q  <= ady3_d;
      rad3_q  <= rad2_q;
      cnx3_q  <= cdx2_q[22];
      cny3_q  <= cdy2_q[22];
      ov3_q   <= ov2_q;
      dirx3_q <= dirx3_d;
      diry3_q <= diry3_d;
    end
  end

  // stage 4
  logic [46:0] s;
  logic        hitc, nz;
  logic        v4_q;
  sq_t         out_d, out_q;

  always_comb begin
    s     = 47'(sx3_q) + 47'(sy3_q);
    hitc  = s < 47'(rr3_q);
    nz    = s != '0;
    out_d = '0;
    out_d.geo.scl4  = mode3_q == MODE_CR;
    out_d.geo.adx   = adx3_q;
    out_d.geo.ady   = ady3_q;
    out_d.geo.rad   = rad3_q;
    out_d.res.neg_x = cnx3_q;
    out_d.res.neg_y = cny3_q;
    unique case (mode3_q)
      MODE_CC: begin
        out_d.res.hit  = hitc;
        out_d.res.circ = hitc & nz;
      end
      MODE_CR: begin
        out_d.res.hit  = hitc;
        out_d.res.circ = hitc & nz;
        if (hitc && !nz) begin
          out_d.res.dir_x = dirx3_q;
          out_d.res.dir_y = diry3_q;
        end
      end
      MODE_RR: begin
        out_d.res.hit = ov3_q;
        if (ov3_q) begin
          out_d.res.dir_x = dirx3_q;
          out_d.res.dir_y = diry3_q;
        end
      end
      MODE_NONE: begin
        out_d.res.hit = 1'b0;
      end
    endcase
    if (out_d.res.circ) begin
      out_d.v = {s[33:0], 16'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign vld_o  = v4_q;
  assign data_o = out_q;

endmodule

>>> rtl/cpr_sqrt_step.sv
// one digit of the pipelined integer square root
module cpr_sqrt_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  cpr_pkg::sq_t data_i,
  output logic         vld_o,
  output cpr_pkg::sq_t data_o
);
  import cpr_pkg::*;

  logic [RadW+1:0] r_sh, t;
  logic            ge;
  sq_t             nxt_d, nxt_q;
  logic            vld_q;

  always_comb begin
    r_sh  = {data_i.rem, data_i.v[SqW-1 -: 2]};
    t     = {2'b0, data_i.root, 2'b01};
    ge    = r_sh >= t;
    nxt_d = data_i;
    nxt_d.v    = {data_i.v[SqW-3:0], 2'b0};
    nxt_d.rem  = ge ? RadW'(r_sh - t) : RadW'(r_sh);
    nxt_d.root = {data_i.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nxt_q <= nxt_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = nxt_q;

endmodule

>>> rtl/cpr_div_prep.sv
// push scale, numerator products and rounding bias ahead of the divider
module cpr_div_prep (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  cpr_pkg::sq_t data_i,
  output logic         vld_o,
  output cpr_pkg::dv_t data_o
);
  import cpr_pkg::*;

  // stage 1: k and divisor
  logic             v1_q, v2_q, v3_q;
  logic [RootW-1:0] k1_d, k1_q;
  logic [RadW-1:0]  d1_d, d1_q, d2_q;
  logic [RadW-2:0]  h1_d, h1_q, h2_q;
  logic [MagW-1:0]  adx1_q, ady1_q;
  res_t             res1_q, res2_q;

  always_comb begin
    k1_d = RootW'({data_i.geo.rad, 8'b0}) - data_i.root;
    if (data_i.geo.scl4) begin
      d1_d = {data_i.root, 2'b0};
      h1_d = {data_i.root, 1'b0};
    end else begin
      d1_d = {1'b0, data_i.root, 1'b0};
      h1_d = {1'b0, data_i.root};
    end
  end

  // stage 2: products
  logic [41:0] px2_q, py2_q;

  // stage 3: numerator split
  logic [42:0] nx, ny;
  dv_t         out_d, out_q;

  always_comb begin
    nx    = 43'(px2_q) + 43'(h2_q);
    ny    = 43'(py2_q) + 43'(h2_q);
    out_d = '0;
    out_d.nlo_x = nx[QuoW-1:0];
    out_d.nlo_y = ny[QuoW-1:0];
    out_d.rem_x = RadW'(nx[42:QuoW]);
    out_d.rem_y = RadW'(ny[42:QuoW]);
    out_d.d     = d2_q;
    out_d.res   = res2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k1_q   <= k1_d;
      d1_q   <= d1_d;
      h1_q   <= h1_d;
      adx1_q <= data_i.geo.adx;
      ady1_q <= data_i.geo.ady;
      res1_q <= data_i.res;
      px2_q  <= 42'(adx1_q) * 42'(k1_q);
      py2_q  <= 42'(ady1_q) * 42'(k1_q);
      d2_q   <= d1_q;
      h2_q   <= h1_q;
      res2_q <= res1_q;
      out_q  <= out_d;
    end
  end

  assign vld_o  = v3_q;
  assign data_o = out_q;

endmodule

>>> rtl/cpr_div_step.sv
// one quotient bit of the two-lane restoring divider
module cpr_div_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  cpr_pkg::dv_t data_i,
  output logic         vld_o,
  output cpr_pkg::dv_t data_o
);
  import cpr_pkg::*;

  logic [RadW:0] rx, ry, dd;
  logic          gx, gy;
  dv_t           nxt_d, nxt_q;
  logic          vld_q;

  always_comb begin
    rx    = {data_i.rem_x, data_i.nlo_x[QuoW-1]};
    ry    = {data_i.rem_y, data_i.nlo_y[QuoW-1]};
    dd    = {1'b0, data_i.d};
    gx    = rx >= dd;
    gy    = ry >= dd;
    nxt_d = data_i;
    nxt_d.rem_x = gx ? RadW'(rx - dd) : RadW'(rx);
    nxt_d.rem_y = gy ? RadW'(ry - dd) : RadW'(ry);
    nxt_d.q_x   = {data_i.q_x[QuoW-2:0], gx};
    nxt_d.q_y   = {data_i.q_y[QuoW-2:0], gy};
    nxt_d.nlo_x = {data_i.nlo_x[QuoW-2:0], 1'b0};
    nxt_d.nlo_y = {data_i.nlo_y[QuoW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nxt_q <= nxt_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = nxt_q;

endmodule

>>> rtl/collision_pair_push_resolver.sv
// top level of the collision pair push resolver
// Takes one shape pair per cycle and returns one result per pair in order,
// passing it through four geometry stages, a 25-stage square root (one root
// bit per stage), three stages that form the scaled numerator, an 18-stage
// divider (one quotient bit per stage, both axes in parallel) and the output
// register. The whole pipeline holds while a finished result waits and the
// output is not ready.
module collision_pair_push_resolver (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height
  input  logic [143:0] s_axis_tdata_i,
  // mode
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // colliding, push_x, push_y, zero fill
  output logic [47:0]  m_axis_tdata_o
);
  import cpr_pkg::*;

  logic        adv;
  logic        sq_vld [RootW+1];
  sq_t         sq_data [RootW+1];
  logic        dv_vld [QuoW+1];
  dv_t         dv_data [QuoW+1];
  logic        out_vld_q;
  logic [47:0] out_data_d, out_data_q;
  logic [19:0] px, py, vx, vy;
  dv_t         fin;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  cpr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .vld_i      (s_axis_tvalid_i),
    .mode_i     (s_axis_tuser_i),
    .a_x_i      (s_axis_tdata_i[19:0]),
    .a_y_i      (s_axis_tdata_i[39:20]),
    .a_width_i  (s_axis_tdata_i[55:40]),
    .a_height_i (s_axis_tdata_i[71:56]),
    .b_x_i      (s_axis_tdata_i[91:72]),
    .b_y_i      (s_axis_tdata_i[111:92]),
    .b_width_i  (s_axis_tdata_i[127:112]),
    .b_height_i (s_axis_tdata_i[143:128]),
    .vld_o      (sq_vld[0]),
    .data_o     (sq_data[0])
  );

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    cpr_sqrt_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (sq_vld[i]),
      .data_i (sq_data[i]),
      .vld_o  (sq_vld[i+1]),
      .data_o (sq_data[i+1])
    );
  end

  cpr_div_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (sq_vld[RootW]),
    .data_i (sq_data[RootW]),
    .vld_o  (dv_vld[0]),
    .data_o (dv_data[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    cpr_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (dv_vld[i]),
      .data_i (dv_data[i]),
      .vld_o  (dv_vld[i+1]),
      .data_o (dv_data[i+1])
    );
  end

  always_comb begin
    fin = dv_data[QuoW];
    vx  = fin.res.neg_x ? 20'd0 - 20'(fin.q_x) : 20'(fin.q_x);
    vy  = fin.res.neg_y ? 20'd0 - 20'(fin.q_y) : 20'(fin.q_y);
    if (!fin.res.hit) begin
      px = '0;
      py = '0;
    end else if (fin.res.circ) begin
      px = vx;
      py = vy;
    end else begin
      px = fin.res.dir_x;
      py = fin.res.dir_y;
    end
    out_data_d = {7'b0, py, px, fin.res.hit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  a_no_hit_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[40:1] == '0)
    else $error("push without collision");

  a_stall_holds_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sq_data[1]) && $stable(sq_vld[1]))
    else $error("root pipeline moved during stall");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

endmodule

>>> tb/testbench.sv
// self-checking testbench for the collision pair push resolver
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpr_pkg::*;

  typedef struct {
    bit               hit;
    logic signed [19:0] px;
    logic signed [19:0] py;
  } push_t;

  class push_scoreboard;
    push_t pending[$];
    int    mismatches = 0;

    function automatic longint isqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function automatic longint round_div(longint n, longint d);
      longint unsigned m;
      longint unsigned q;
      m = n < 0 ? longint'(-n) : n;
      q = (m + d / 2) / d;
      return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [19:0] clip(longint v);
      if (v > 524287) return 20'sh7FFFF;
      if (v < -524288) return 20'sh80000;
      return v[19:0];
    endfunction

    function automatic longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
    endfunction

    function automatic void note_pair(logic [1:0] mode, logic [143:0] d);
      longint ax, ay, aw, ah, bx, by, bw, bh, dx, dy, sr, m8, k, f;
      longint cx, cy, rx, ry, rad, ox, oy;
      longint unsigned s;
      push_t r;
      ax = longint'($signed(d[19:0]));  ay = longint'($signed(d[39:20]));
      aw = d[55:40];  ah = d[71:56];
      bx = longint'($signed(d[91:72])); by = longint'($signed(d[111:92]));
      bw = d[127:112]; bh = d[143:128];
      r.hit = 0; dx = 0; dy = 0; f = 0;
      r.px = 0; r.py = 0;
      if (mode == MODE_CC) begin
        dx = ax - bx; dy = ay - by; sr = aw + bw;
        s = dx * dx + dy * dy;
        if (s < sr * sr) begin
          r.hit = 1;
          if (s != 0) begin
            m8 = isqrt(s << 16); k = sr * 256 - m8;
            r.px = clip(round_div(dx * k, 2 * m8));
            r.py = clip(round_div(dy * k, 2 * m8));
          end
        end
      end else if (mode == MODE_CR) begin
        cx = 2 * ax; cy = 2 * ay; rad = 2 * aw; rx = 2 * bx; ry = 2 * by;
        dx = cx - clampv(cx, rx - bw, rx + bw);
        dy = cy - clampv(cy, ry - bh, ry + bh);
        s = dx * dx + dy * dy;
        if (s < rad * rad) begin
          r.hit = 1;
          if (s == 0) begin
            ox = cx - rx; oy = cy - ry;
            dx = bw - mag(ox) + rad; dy = bh - mag(oy) + rad;
            if (ox < 0) dx = -dx;
            if (oy < 0) dy = -dy;
            r.px = clip(round_div(dx, 4)); r.py = clip(round_div(dy, 4));
          end else begin
            m8 = isqrt(s << 16); k = rad * 256 - m8;
            r.px = clip(round_div(dx * k, 4 * m8));
            r.py = clip(round_div(dy * k, 4 * m8));
          end
        end
      end else if (mode == MODE_RR) begin
        ax *= 2; ay *= 2; bx *= 2; by *= 2;
        if (ax + aw > bx - bw && ax - aw < bx + bw &&
            ay + ah > by - bh && ay - ah < by + bh) begin
          dx = ax - bx; dy = ay - by; r.hit = 1;
          if (mag(dx) > mag(dy) || (dx == 0 && dy == 0)) begin
            f = dx < 0 ? (bx - bw) - (ax + aw) : (bx + bw) - (ax - aw);
            r.px = clip(round_div(f, 4));
          end else begin
            f = dy < 0 ? (by - bh) - (ay + ah) : (by + bh) - (ay - ah);
            r.py = clip(round_div(f, 4));
          end
        end
      end
      pending = {pending, r};
    endfunction

    function automatic void check_result(logic [47:0] d);
      push_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.hit || d[20:1] !== e.px || d[40:21] !== e.py ||
          d[47:41] !== 7'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit %0d x %0d y %0d, got hit %0d x %0d y %0d",
                   e.hit, e.px, e.py, d[0], $signed(d[20:1]), $signed(d[40:21]));
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [47:0]  m_axis_tdata_o;

  push_scoreboard sb = new();
  int  cycles = 0;
  bit  sending_done = 0;
  bit  long_hold = 0;
  bit  hold_done = 0;

  collision_pair_push_resolver DUT (.*);

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(2);
  endfunction

  task automatic send_pair(logic [1:0] mode, logic [143:0] d);
    int g;
    g = ($urandom_range(3) == 0) ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_pair(mode, d);
  endtask

  function automatic logic [19:0] rand_pos(int near);
    logic [19:0] p;
    p = $urandom;
    if (near) p = $signed(20'($urandom_range(2000))) - 20'sd1000;
    return p;
  endfunction

  function automatic logic [143:0] pack_pair(logic [19:0] ax, ay, logic [15:0] aw, ah,
                                             logic [19:0] bx, by, logic [15:0] bw, bh);
    return {bh, bw, by, bx, ah, aw, ay, ax};
  endfunction

  task automatic send_random();
    int near;
    logic [19:0] ax, ay, bx, by;
    logic [15:0] aw, ah, bw, bh;
    near = $urandom_range(4) != 0;
    ax = rand_pos(near); ay = rand_pos(near);
    bx = near ? ax + rand_pos(1) : rand_pos(0);
    by = near ? ay + rand_pos(1) : rand_pos(0);
    if ($urandom_range(7) == 0) begin by = ay; end
    if ($urandom_range(9) == 0) begin bx = ax; by = ay; end
    aw = near ? $urandom_range(1500) : $urandom; ah = near ? $urandom_range(1500) : $urandom;
    bw = near ? $urandom_range(1500) : $urandom; bh = near ? $urandom_range(1500) : $urandom;
    send_pair(($urandom_range(19) == 0) ? MODE_NONE : mode_e'($urandom_range(2)),
              pack_pair(ax, ay, aw, ah, bx, by, bw, bh));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    for (int m = 0; m < 4; m++) begin
      send_pair(m, pack_pair(0, 0, 16, 16, 0, 0, 16, 16));
      send_pair(m, pack_pair(20'h7FFFF, 20'h80000, 16'hFFFF, 16'hFFFF,
                             20'h80000, 20'h7FFFF, 16'hFFFF, 16'hFFFF));
      send_pair(m, pack_pair(20'h80000, 20'h80000, 16'hFFFF, 16'hFFFF,
                             20'h7FFFF, 20'h7FFFF, 16'hFFFF, 16'hFFFF));
    end
    send_pair(MODE_CC, pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(MODE_CR, pack_pair(10, 5, 8, 0, 0, 0, 64, 32));
    send_pair(MODE_CR, pack_pair(-10, -5, 8, 0, 0, 0, 64, 32));
    send_pair(MODE_CR, pack_pair(40, 0, 16, 0, 0, 0, 64, 32));
    send_pair(MODE_RR, pack_pair(8, 8, 32, 32, 0, 0, 32, 32));
    send_pair(MODE_RR, pack_pair(-4, 12, 32, 32, 0, 0, 32, 32));
    send_pair(MODE_RR, pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(MODE_CC, pack_pair(100, 0, 16, 0, 0, 0, 16, 0));
    for (int i = 0; i < 560; i++) send_random();
    s_axis_tvalid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 570; i++) begin
      if (i == 20) long_hold = 1;
      send_random();
    end
    s_axis_tvalid_i <= 0;
    sending_done = 1;
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (long_hold && !hold_done) begin
        m_axis_tready_i <= 0;
        repeat (300) @(posedge clk_i);
        hold_done = 1;
      end
      g = ($urandom_range(2) == 0) ? gap_len() : 0;
      if (g != 0) begin
        m_axis_tready_i <= 0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready_i <= 1;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i)
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
